// ----- hdl/pip_pkg.sv -----
// shared constants and types for the point in polygon crossing test
package pip_pkg;

    // default coordinate width of the vertex and query fields
    localparam int COORD_WIDTH_DEF = 16;

    // entries of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // configuration register indexes
    localparam int CFG_ADDR_WIDTH = 1;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_QUERY_X = 1'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_QUERY_Y = 1'd1;

    // result word: location in bits 1:0, inside flag in bit 2
    localparam int OUT_DATA_WIDTH = 8;

    // location codes
    localparam int LOC_WIDTH = 2;
    localparam logic [LOC_WIDTH-1:0] LOC_OUTSIDE   = 2'd0;
    localparam logic [LOC_WIDTH-1:0] LOC_INSIDE    = 2'd1;
    localparam logic [LOC_WIDTH-1:0] LOC_ON_VERTEX = 2'd2;
    localparam logic [LOC_WIDTH-1:0] LOC_ON_EDGE   = 2'd3;

    // per-vertex control carried through the queue
    typedef struct packed {
        logic hit;        // vertex coincides with the query point
        logic last;       // vertex closes the polygon
        logic edge0_vld;  // edge from previous vertex is present
        logic edge1_vld;  // closing edge to first vertex is present
    } pip_flags_t;

endpackage

// ----- hdl/pip_front.sv -----
// front part: query registers, vertex shift and edge formation
module pip_front #(
    parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [pip_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [COORD_WIDTH-1:0]            cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [COORD_WIDTH-1:0]            vertex_x,
    input  logic [COORD_WIDTH-1:0]            vertex_y,
    input  logic                              last_vertex,
    output logic                              q_valid,
    input  logic                              q_ready,
    output pip_pkg::pip_flags_t               q_flags,
    output logic [8*(COORD_WIDTH+1)-1:0]      q_data
);
    import pip_pkg::*;

    localparam int SW = COORD_WIDTH + 1;

    logic [COORD_WIDTH-1:0] query_x_reg, query_y_reg;
    logic [SW-1:0]          first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic                   have_first_reg, have_first_next;
    logic [SW-1:0]          cx, cy, fx, fy;
    logic                   accept;

    assign in_ready = q_ready;
    assign q_valid  = in_valid;
    assign accept   = in_valid && q_ready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_x_reg <= '0;
            query_y_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_addr == CFG_QUERY_X) begin
                query_x_reg <= cfg_wdata;
            end
            if (cfg_addr == CFG_QUERY_Y) begin
                query_y_reg <= cfg_wdata;
            end
        end
    end

    // shift the vertex so the query point is the origin
    assign cx = SW'($signed({vertex_x[COORD_WIDTH-1], vertex_x})
                  - $signed({query_x_reg[COORD_WIDTH-1], query_x_reg}));
    assign cy = SW'($signed({vertex_y[COORD_WIDTH-1], vertex_y})
                  - $signed({query_y_reg[COORD_WIDTH-1], query_y_reg}));

    // first vertex of the polygon, the current one if none held yet
    assign fx = have_first_reg ? first_x_reg : cx;
    assign fy = have_first_reg ? first_y_reg : cy;

    // queue word: edge0 then edge1, each xi, yi, xp, yp from the lowest bit
    assign q_data = {fy, fx, cy, cx, prev_y_reg, prev_x_reg, cy, cx};

    always_comb begin
        q_flags.hit       = (cx == '0) && (cy == '0);
        q_flags.last      = last_vertex;
        q_flags.edge0_vld = have_first_reg;
        q_flags.edge1_vld = last_vertex;
    end

    // polygon start tracking
    always_comb begin
        have_first_next = have_first_reg;
        if (accept) begin
            have_first_next = !last_vertex;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_first_reg <= 1'b0;
        end else begin
            have_first_reg <= have_first_next;
        end
    end

    // vertex storage
    always_ff @(posedge aclk) begin
        if (accept) begin
            prev_x_reg <= cx;
            prev_y_reg <= cy;
            if (!have_first_reg) begin
                first_x_reg <= cx;
                first_y_reg <= cy;
            end
        end
    end

endmodule

// ----- hdl/pip_queue.sv -----
// short register queue between front and back
module pip_queue #(
    parameter int DATA_WIDTH = 8,
    parameter int DEPTH      = pip_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  logic [DATA_WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output logic [DATA_WIDTH-1:0] pop_data
);
    import pip_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = store_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hdl/pip_back.sv -----
// back part: cross products, crossing parities and result word
module pip_back #(
    parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 pop_valid,
    output logic                                 pop_ready,
    input  pip_pkg::pip_flags_t                  pop_flags,
    input  logic [8*(COORD_WIDTH+1)-1:0]         pop_data,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output logic [pip_pkg::LOC_WIDTH-1:0]        location,
    output logic                                 inside_res
);
    import pip_pkg::*;

    localparam int SW = COORD_WIDTH + 1;
    localparam int PW = 2 * SW;

    logic signed [SW-1:0] xi [2];
    logic signed [SW-1:0] yi [2];
    logic signed [SW-1:0] xp [2];
    logic signed [SW-1:0] yp [2];
    logic                 rs [2];
    logic                 ls [2];
    logic                 evld [2];

    logic                 s1_valid_reg, s1_valid_next;
    pip_flags_t           s1_flags_reg;
    logic signed [PW-1:0] s1_p1_reg [2];
    logic signed [PW-1:0] s1_p2_reg [2];
    logic                 s1_rs_reg [2];
    logic                 s1_ls_reg [2];
    logic                 s1_up_reg [2];

    logic signed [PW:0]   diff [2];
    logic                 tog_r [2];
    logic                 tog_l [2];

    logic                 rpar_reg, rpar_next, lpar_reg, lpar_next, hit_reg, hit_next;
    logic                 rpar_new, lpar_new, hit_new;
    logic                 res_valid_reg, res_valid_next;
    logic [LOC_WIDTH-1:0] loc_reg, loc_next;
    logic                 advance;

    assign advance   = !res_valid_reg || res_ready;
    assign pop_ready = advance;
    assign evld[0]   = pop_flags.edge0_vld;
    assign evld[1]   = pop_flags.edge1_vld;

    // unpack edges and find straddles of the x axis
    always_comb begin
        for (int e = 0; e < 2; e++) begin
            xi[e] = pop_data[(4*e)*SW +: SW];
            yi[e] = pop_data[(4*e+1)*SW +: SW];
            xp[e] = pop_data[(4*e+2)*SW +: SW];
            yp[e] = pop_data[(4*e+3)*SW +: SW];
            rs[e] = evld[e] && ((yi[e] > 0) != (yp[e] > 0));
            ls[e] = evld[e] && ((yi[e] < 0) != (yp[e] < 0));
        end
    end

    // stage one: products xi*yp and xp*yi
    always_ff @(posedge aclk) begin
        if (advance && pop_valid) begin
            s1_flags_reg <= pop_flags;
            for (int e = 0; e < 2; e++) begin
                s1_p1_reg[e] <= xi[e] * yp[e];
                s1_p2_reg[e] <= xp[e] * yi[e];
                s1_rs_reg[e] <= rs[e];
                s1_ls_reg[e] <= ls[e];
                s1_up_reg[e] <= (yp[e] > yi[e]);
            end
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (advance) begin
            s1_valid_next = pop_valid;
        end
    end

    // stage two: sign of the crossing and parity toggles
    always_comb begin
        for (int e = 0; e < 2; e++) begin
            diff[e]  = $signed({s1_p1_reg[e][PW-1], s1_p1_reg[e]})
                     - $signed({s1_p2_reg[e][PW-1], s1_p2_reg[e]});
            tog_r[e] = s1_rs_reg[e] && (s1_up_reg[e] ? (diff[e] > 0) : (diff[e] < 0));
            tog_l[e] = s1_ls_reg[e] && (s1_up_reg[e] ? (diff[e] < 0) : (diff[e] > 0));
        end
        rpar_new = rpar_reg ^ tog_r[0] ^ tog_r[1];
        lpar_new = lpar_reg ^ tog_l[0] ^ tog_l[1];
        hit_new  = hit_reg | s1_flags_reg.hit;
    end

    // polygon state and result word
    always_comb begin
        rpar_next      = rpar_reg;
        lpar_next      = lpar_reg;
        hit_next       = hit_reg;
        res_valid_next = res_valid_reg;
        loc_next       = loc_reg;
        if (advance) begin
            res_valid_next = 1'b0;
            if (s1_valid_reg) begin
                if (s1_flags_reg.last) begin
                    res_valid_next = 1'b1;
                    rpar_next      = 1'b0;
                    lpar_next      = 1'b0;
                    hit_next       = 1'b0;
                    if (hit_new) begin
                        loc_next = LOC_ON_VERTEX;
                    end else if (rpar_new != lpar_new) begin
                        loc_next = LOC_ON_EDGE;
                    end else if (rpar_new) begin
                        loc_next = LOC_INSIDE;
                    end else begin
                        loc_next = LOC_OUTSIDE;
                    end
                end else begin
                    rpar_next = rpar_new;
                    lpar_next = lpar_new;
                    hit_next  = hit_new;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            rpar_reg      <= 1'b0;
            lpar_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            rpar_reg      <= rpar_next;
            lpar_reg      <= lpar_next;
            hit_reg       <= hit_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        loc_reg <= loc_next;
    end

    assign res_valid  = res_valid_reg;
    assign location   = loc_reg;
    assign inside_res = (loc_reg == LOC_INSIDE);

endmodule

// ----- hdl/point_in_polygon_test_core.sv -----
// Crossing-parity point in polygon test, one vertex word per cycle while s_tready is high.
// Throughput: one vertex word per cycle when not stalled; one result word per polygon.
// The result word is registered after the last vertex is taken, passing in order through
// the queue, the product stage and the parity stage with output register.
// The four-entry queue absorbs output stalls; s_tready drops when it is full.
// Reset (aresetn low, synchronous) clears query registers, queue and parities.
module point_in_polygon_test_core #(
    parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF,
    parameter int QUEUE_DEPTH = pip_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_we,
    input  logic [pip_pkg::CFG_ADDR_WIDTH-1:0]      cfg_addr,
    input  logic [COORD_WIDTH-1:0]                  cfg_wdata,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // vertex_x, vertex_y, zero fill
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]      s_tdata,
    input  logic                                    s_tlast,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // location (2), inside_res (1), zero fill
    output logic [pip_pkg::OUT_DATA_WIDTH-1:0]      m_tdata
);
    import pip_pkg::*;

    localparam int SW    = COORD_WIDTH + 1;
    localparam int EDW   = 8 * SW;
    localparam int FLW   = $bits(pip_flags_t);
    localparam int QW    = EDW + FLW;

    logic                 fq_valid, fq_ready, qb_valid, qb_ready;
    pip_flags_t           fq_flags, qb_flags;
    logic [EDW-1:0]       fq_data;
    logic [QW-1:0]        qb_word;
    logic [LOC_WIDTH-1:0] location;
    logic                 inside_res;

    // front: shift and edge formation
    pip_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .vertex_x    (s_tdata[COORD_WIDTH-1:0]),
        .vertex_y    (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .last_vertex (s_tlast),
        .q_valid     (fq_valid),
        .q_ready     (fq_ready),
        .q_flags     (fq_flags),
        .q_data      (fq_data)
    );

    // queue between the two parts
    pip_queue #(
        .DATA_WIDTH (QW),
        .DEPTH      (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  ({fq_flags, fq_data}),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_word)
    );

    assign qb_flags = pip_flags_t'(qb_word[QW-1:EDW]);

    // back: crossing test and result
    pip_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_flags  (qb_flags),
        .pop_data   (qb_word[EDW-1:0]),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .location   (location),
        .inside_res (inside_res)
    );

    assign m_tdata = {{(OUT_DATA_WIDTH - LOC_WIDTH - 1){1'b0}}, inside_res, location};

endmodule

// ----- hdl/pip_checker.sv -----
// port-level checks on the result channel, bound to the top level
module pip_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [pip_pkg::OUT_DATA_WIDTH-1:0] m_tdata
);
    import pip_pkg::*;

    // no result word right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // inside flag agrees with the location code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[LOC_WIDTH] == (m_tdata[LOC_WIDTH-1:0] == LOC_INSIDE)))
        else $error("inside flag disagrees with location");

    // fill bits stay zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_DATA_WIDTH-1:LOC_WIDTH+1] == '0))
        else $error("fill bits of result word not zero");

endmodule

bind point_in_polygon_test_core pip_checker u_pip_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- dv/point_in_polygon_test_core_tb.sv -----
// self-checking testbench for the point in polygon crossing test core
`timescale 1ns / 1ps

module point_in_polygon_test_core_tb;
    import pip_pkg::*;

    localparam int W           = COORD_WIDTH_DEF;
    localparam int DATA_W      = ((2 * W + 7) / 8) * 8;
    localparam int SETTLE      = 12;
    localparam int LIMIT_CYCLES = 500000;
    localparam int HOLD_CYCLES = 200;

    // random polygon shapes
    typedef enum int {
        SHAPE_NOISE,
        SHAPE_NEAR,
        SHAPE_BOX,
        SHAPE_SPREAD
    } shape_t;

    // one expected result word
    typedef struct packed {
        logic [LOC_WIDTH-1:0] loc;
        logic                 inside_bit;
    } location_t;

    // crossing parity predictor and store of expected locations
    class polygon_locator;
        logic signed [W-1:0] qx, qy;
        logic signed [W:0]   first_x, first_y, prev_x, prev_y;
        bit                  have_first, right_par, left_par, hit_vertex;
        location_t           pending[$];
        int                  mismatches;

        function new();
            qx = '0;
            qy = '0;
            first_x = '0;
            first_y = '0;
            prev_x = '0;
            prev_y = '0;
            have_first = 0;
            right_par = 0;
            left_par = 0;
            hit_vertex = 0;
            mismatches = 0;
        endfunction

        function void set_query(logic [CFG_ADDR_WIDTH-1:0] addr, logic [W-1:0] value);
            if (addr == CFG_QUERY_X) begin
                qx = value;
            end else begin
                qy = value;
            end
        endfunction

        // edge from (xp,yp) to (xi,yi); exact sign of the axis crossing
        function void cross_edge(logic signed [W:0] xi, logic signed [W:0] yi,
                                 logic signed [W:0] xp, logic signed [W:0] yp);
            longint num;
            bit     up_straddle, down_straddle;
            int     s, xs;
            up_straddle   = (yi > 0) != (yp > 0);
            down_straddle = (yi < 0) != (yp < 0);
            if (!up_straddle && !down_straddle) return;
            num = longint'(xi) * longint'(yp) - longint'(xp) * longint'(yi);
            s = (num > 0) ? 1 : ((num < 0) ? -1 : 0);
            xs = (yp > yi) ? s : -s;
            if (up_straddle && xs > 0) right_par = !right_par;
            if (down_straddle && xs < 0) left_par = !left_par;
        endfunction

        // accepted vertex word
        function void take_vertex(logic [W-1:0] vx, logic [W-1:0] vy, bit last);
            logic signed [W:0] cx, cy;
            location_t         res;
            cx = $signed({vx[W-1], vx}) - $signed({qx[W-1], qx});
            cy = $signed({vy[W-1], vy}) - $signed({qy[W-1], qy});
            if (cx == 0 && cy == 0) hit_vertex = 1;
            if (have_first) begin
                cross_edge(cx, cy, prev_x, prev_y);
            end else begin
                first_x = cx;
                first_y = cy;
                have_first = 1;
            end
            prev_x = cx;
            prev_y = cy;
            if (!last) return;
            // closing edge back to the first vertex
            cross_edge(first_x, first_y, cx, cy);
            if (hit_vertex) begin
                res.loc = LOC_ON_VERTEX;
            end else if (right_par != left_par) begin
                res.loc = LOC_ON_EDGE;
            end else begin
                res.loc = right_par ? LOC_INSIDE : LOC_OUTSIDE;
            end
            res.inside_bit = (res.loc == LOC_INSIDE);
            pending = {pending, res};
            have_first = 0;
            right_par = 0;
            left_par = 0;
            hit_vertex = 0;
        endfunction

        // accepted result word against the oldest expectation
        function void check_location(logic [OUT_DATA_WIDTH-1:0] word);
            location_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result word, location %0d inside %0b",
                         $time, word[LOC_WIDTH-1:0], word[LOC_WIDTH]);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (word[LOC_WIDTH-1:0] !== want.loc) begin
                $display("%0t: location mismatch, expected %0d actual %0d",
                         $time, want.loc, word[LOC_WIDTH-1:0]);
                mismatches++;
            end
            if (word[LOC_WIDTH] !== want.inside_bit) begin
                $display("%0t: inside flag mismatch, expected %0b actual %0b",
                         $time, want.inside_bit, word[LOC_WIDTH]);
                mismatches++;
            end
        endfunction
    endclass

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0] cfg_addr  = CFG_QUERY_X;
    logic [W-1:0]              cfg_wdata = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    // vertex_x, vertex_y, zero fill
    logic [DATA_W-1:0]         s_tdata   = '0;
    logic                      s_tlast   = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    // location (2), inside_res (1), zero fill
    logic [OUT_DATA_WIDTH-1:0] m_tdata;

    polygon_locator locator = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_req = 0;
    int  hold_left = 0;
    int  cycle_count = 0;
    int  vertices_sent = 0;

    point_in_polygon_test_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: check accepted words, random stalls, long hold-off
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) locator.check_location(m_tdata);
        if (hold_req && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // write both query registers while the core is idle
    task automatic set_query(input logic [W-1:0] x, input logic [W-1:0] y);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_QUERY_X;
        cfg_wdata <= x;
        @(posedge aclk);
        locator.set_query(CFG_QUERY_X, x);
        cfg_addr  <= CFG_QUERY_Y;
        cfg_wdata <= y;
        @(posedge aclk);
        locator.set_query(CFG_QUERY_Y, y);
        cfg_we <= 1'b0;
    endtask

    // offer one vertex word with a random gap ahead of it
    task automatic send_vertex(input logic [W-1:0] vx, input logic [W-1:0] vy, input bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'({vy, vx});
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        locator.take_vertex(vx, vy, last);
        vertices_sent++;
    endtask

    // stop offering, let every result arrive, then let the pipeline settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (locator.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [W-1:0] near(input logic [W-1:0] base, input int span);
        return base + W'(int'($urandom_range(2 * span)) - span);
    endfunction

    // one random polygon; close clear leaves it open
    task automatic send_polygon(input shape_t shape, input bit close);
        int n, span, a, b, c, d;
        logic [W-1:0] bx[4];
        logic [W-1:0] by[4];
        case (shape)
            SHAPE_NOISE: begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_vertex(W'($urandom), W'($urandom), close && i == n - 1);
            end
            SHAPE_NEAR: begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_vertex(near(locator.qx, 3), near(locator.qy, 3), close && i == n - 1);
            end
            SHAPE_BOX: begin
                case ($urandom_range(2))
                    0: span = 2;
                    1: span = 500;
                    default: span = 40000;
                endcase
                a = $urandom_range(span);
                b = $urandom_range(span);
                c = $urandom_range(span);
                d = $urandom_range(span);
                bx[0] = locator.qx - W'(a); by[0] = locator.qy - W'(b);
                bx[1] = locator.qx + W'(c); by[1] = locator.qy - W'(b);
                bx[2] = locator.qx + W'(c); by[2] = locator.qy + W'(d);
                bx[3] = locator.qx - W'(a); by[3] = locator.qy + W'(d);
                // either winding direction
                if ($urandom_range(1)) begin
                    for (int i = 0; i < 4; i++) send_vertex(bx[i], by[i], close && i == 3);
                end else begin
                    for (int i = 3; i >= 0; i--) send_vertex(bx[i], by[i], close && i == 0);
                end
            end
            default: begin
                n = $urandom_range(3, 8);
                for (int i = 0; i < n; i++)
                    send_vertex(near(locator.qx, 300), near(locator.qy, 300), close && i == n - 1);
            end
        endcase
    endtask

    function automatic shape_t pick_shape();
        int r;
        r = $urandom_range(99);
        if (r < 20) return SHAPE_NOISE;
        if (r < 45) return SHAPE_NEAR;
        if (r < 75) return SHAPE_BOX;
        return SHAPE_SPREAD;
    endfunction

    // main sequence
    initial begin
        logic [W-1:0] phase_qx, phase_qy;
        int budget;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed polygons with the query at its reset value
        send_vertex(16'd0, 16'd0, 1'b1);                // single vertex on the query point
        send_vertex(16'd7, 16'd7, 1'b1);                // single vertex away from it
        send_vertex(-16'sd10, -16'sd10, 1'b0);          // square around the query point
        send_vertex(16'd10, -16'sd10, 1'b0);
        send_vertex(16'd10, 16'd10, 1'b0);
        send_vertex(-16'sd10, 16'd10, 1'b1);
        send_vertex(16'h8000, 16'h8000, 1'b0);          // full-range square
        send_vertex(16'h7fff, 16'h8000, 1'b0);
        send_vertex(16'h7fff, 16'h7fff, 1'b0);
        send_vertex(16'h8000, 16'h7fff, 1'b1);
        send_vertex(16'd0, -16'sd5, 1'b0);              // edge crossing the axis at the query point
        send_vertex(16'd0, 16'd5, 1'b0);
        send_vertex(-16'sd5, 16'd0, 1'b1);
        send_vertex(-16'sd4, -16'sd4, 1'b0);            // vertex hit wins over inside
        send_vertex(16'd4, -16'sd4, 1'b0);
        send_vertex(16'd0, 16'd0, 1'b1);
        send_vertex(16'd5, -16'sd5, 1'b0);              // square to the right, outside
        send_vertex(16'd9, -16'sd5, 1'b0);
        send_vertex(16'd9, 16'd5, 1'b0);
        send_vertex(16'd5, 16'd5, 1'b1);
        wait_idle();

        // extreme query values give the widest shifted coordinates
        set_query(16'h8000, 16'h7fff);
        send_vertex(16'h7fff, 16'h8000, 1'b1);
        send_vertex(16'h7fff, 16'h8000, 1'b0);
        send_vertex(16'h7fff, 16'h7fff, 1'b0);
        send_vertex(16'h8000, 16'h8000, 1'b1);
        wait_idle();
        set_query(16'h7fff, 16'h8000);
        send_vertex(16'h8000, 16'h7fff, 1'b0);
        send_vertex(16'h8000, 16'h8000, 1'b0);
        send_vertex(16'h7fff, 16'h7fff, 1'b1);
        wait_idle();

        // random phases over the idling modes and several query points
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin phase_qx = 16'd0;    phase_qy = 16'd0;    end
                1: begin phase_qx = 16'h8000; phase_qy = 16'h8000; end
                2: begin phase_qx = 16'h7fff; phase_qy = 16'h7fff; end
                3: begin phase_qx = 16'h8000; phase_qy = 16'h7fff; end
                default: begin
                    phase_qx = W'($urandom);
                    phase_qy = W'($urandom);
                end
            endcase
            set_query(phase_qx, phase_qy);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            budget = vertices_sent + 98;
            while (vertices_sent < budget) send_polygon(pick_shape(), 1'b1);
            // odd phases leave a polygon open across the query change
            if (p % 2 == 1) send_polygon(SHAPE_SPREAD, 1'b0);
            wait_idle();
        end

        // long receiver hold-off while small polygons near the query keep coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1;
        for (int i = 0; i < 30; i++) send_polygon(SHAPE_NEAR, 1'b1);
        wait_idle();

        if (locator.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/pip_pkg.sv
hdl/pip_front.sv
hdl/pip_queue.sv
hdl/pip_back.sv
hdl/point_in_polygon_test_core.sv
hdl/pip_checker.sv
dv/point_in_polygon_test_core_tb.sv
